@@ rtl/wes_pkg.sv @@
`timescale 1ns / 1ps

package wes_pkg;

    // Q-format of every value, weight and coefficient.
    localparam int VW = 32;
    localparam int FB = 16;

    // Derived widths of the datapath.
    localparam int SW  = VW + 1;        // neighbor sums and differences
    localparam int CPW = 2 * VW;        // center weight times center value
    localparam int PW  = VW + SW;       // weight times neighbor sum
    localparam int LW  = PW + 2;        // sum of the four linear products
    localparam int QW  = 2 * SW;        // difference times coefficient difference
    localparam int LOW = SW;            // low part of the split coefficient product
    localparam int HIW = QW - LOW;      // high part of the split coefficient product
    localparam int AW  = VW + QW + 4;   // full-precision accumulator

    // Configuration register indexes.
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] CFG_MODE     = CFG_IW'(0);
    localparam logic [CFG_IW-1:0] CFG_W_CENTER = CFG_IW'(1);
    localparam logic [CFG_IW-1:0] CFG_W_X      = CFG_IW'(2);
    localparam logic [CFG_IW-1:0] CFG_W_Y      = CFG_IW'(3);
    localparam logic [CFG_IW-1:0] CFG_W_Z      = CFG_IW'(4);

    // Reset value of the center weight: 2.0.
    localparam logic [VW-1:0] W_CENTER_RST = VW'(2) << FB;

    // Output limits.
    localparam logic [VW-1:0] Y_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] Y_MIN = {1'b1, {(VW-1){1'b0}}};

endpackage

@@ rtl/wave_equation_stencil_update.sv @@
`timescale 1ns / 1ps

// Latency: a result strobes on o_valid once the node that start accepted has passed every stage.
// Throughput: one node per cycle; busy stays low, and the seven register stages (pre-add,
// two rounds of multiplies, recombination, two accumulation adds, saturation) are fed freely.
// Reset: synchronous, active low; clears the stage valid bits and loads the
// registers with 2D mode, center weight 2.0 and zero neighbor weights.
module wave_equation_stencil_update (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [wes_pkg::CFG_IW-1:0]    i_cfg_idx,
    input  logic [wes_pkg::VW-1:0]        i_cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic [wes_pkg::VW-1:0]        i_x_center,
    input  logic [wes_pkg::VW-1:0]        i_x_minus_x,
    input  logic [wes_pkg::VW-1:0]        i_x_plus_x,
    input  logic [wes_pkg::VW-1:0]        i_x_minus_y,
    input  logic [wes_pkg::VW-1:0]        i_x_plus_y,
    input  logic [wes_pkg::VW-1:0]        i_x_minus_z,
    input  logic [wes_pkg::VW-1:0]        i_x_plus_z,
    input  logic [wes_pkg::VW-1:0]        i_y_prev,
    input  logic [wes_pkg::VW-1:0]        i_coef_center,
    input  logic [wes_pkg::VW-1:0]        i_coef_plus_x,
    input  logic [wes_pkg::VW-1:0]        i_coef_plus_y,
    input  logic                          i_in_region,
    output logic                          o_valid,
    output logic [wes_pkg::VW-1:0]        o_y_next,
    output logic                          o_saturated
);
    import wes_pkg::*;

    localparam int NSTG = 6;
    localparam logic signed [AW-1:0] RND = AW'(1) <<< (2 * FB - 1);
    localparam logic [SW-1:0] DB_ONE = SW'(1) << FB;

    // Configuration registers.
    logic                  r_mode;
    logic signed [VW-1:0]  r_wc, r_wx, r_wy, r_wz;

    // Stage valid bits.
    logic [NSTG-1:0]       r_vld;

    // Stage 1: pre-adds.
    logic signed [VW-1:0]  r_xc1, r_yp1;
    logic signed [SW-1:0]  r_sx, r_sy, r_sz, r_dx, r_dy, r_dbx, r_dby;

    // Stage 2: first products.
    logic signed [VW-1:0]  r_yp2;
    logic signed [CPW-1:0] r_pc;
    logic signed [PW-1:0]  r_px, r_py, r_pz;
    logic signed [QW-1:0]  r_qx, r_qy;

    // Stage 3: partial linear sums and weight times split coefficient products.
    logic signed [VW-1:0]      r_yp3;
    logic signed [LW-1:0]      r_la, r_lb;
    logic signed [VW+HIW-1:0]  r_mxh, r_myh;
    logic signed [VW+LOW:0]    r_mxl, r_myl;

    // Stage 4: linear sum and recombined coefficient terms.
    logic signed [VW-1:0]  r_yp4;
    logic signed [LW-1:0]  r_lin;
    logic signed [AW-1:0]  r_tx, r_ty;

    // Stage 5 and 6: accumulation.
    logic signed [AW-1:0]  r_u, r_v, r_acc;

    // Output stage.
    logic                  n_sat;
    logic [VW-1:0]         n_y;
    logic [AW-2*FB-VW:0]   w_top;

    // The pipeline never stalls.
    assign busy = 1'b0;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_wc   <= W_CENTER_RST;
            r_wx   <= '0;
            r_wy   <= '0;
            r_wz   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:     r_mode <= i_cfg_data[0];
                CFG_W_CENTER: r_wc   <= i_cfg_data;
                CFG_W_X:      r_wx   <= i_cfg_data;
                CFG_W_Y:      r_wy   <= i_cfg_data;
                CFG_W_Z:      r_wz   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_vld   <= {r_vld[NSTG-2:0], start & ~busy};
            o_valid <= r_vld[NSTG-1];
        end
    end

    // Stage 1: neighbor sums, differences and coefficient differences.
    // Terms that the current mode does not use are forced to zero.
    always_ff @(posedge i_clk) begin
        r_xc1 <= i_x_center;
        r_yp1 <= i_y_prev;
        r_sx  <= {i_x_minus_x[VW-1], i_x_minus_x} + {i_x_plus_x[VW-1], i_x_plus_x};
        r_sy  <= {i_x_minus_y[VW-1], i_x_minus_y} + {i_x_plus_y[VW-1], i_x_plus_y};
        if (r_mode) begin
            r_sz  <= {i_x_minus_z[VW-1], i_x_minus_z} + {i_x_plus_z[VW-1], i_x_plus_z};
            r_dx  <= '0;
            r_dy  <= '0;
            r_dbx <= '0;
            r_dby <= '0;
        end else begin
            r_sz <= '0;
            r_dx <= {i_x_plus_x[VW-1], i_x_plus_x} - {i_x_center[VW-1], i_x_center};
            r_dy <= {i_x_plus_y[VW-1], i_x_plus_y} - {i_x_center[VW-1], i_x_center};
            if (i_in_region) begin
                r_dbx <= DB_ONE;
                r_dby <= DB_ONE;
            end else begin
                r_dbx <= {i_coef_plus_x[VW-1], i_coef_plus_x}
                       - {i_coef_center[VW-1], i_coef_center};
                r_dby <= {i_coef_plus_y[VW-1], i_coef_plus_y}
                       - {i_coef_center[VW-1], i_coef_center};
            end
        end
    end

    // Stage 2: one multiply per term.
    always_ff @(posedge i_clk) begin
        r_yp2 <= r_yp1;
        r_pc  <= r_wc * r_xc1;
        r_px  <= r_wx * r_sx;
        r_py  <= r_wy * r_sy;
        r_pz  <= r_wz * r_sz;
        r_qx  <= r_dx * r_dbx;
        r_qy  <= r_dy * r_dby;
    end

    // Stage 3: pair up linear products; multiply the weights into the
    // coefficient products, split into a signed high and an unsigned low half.
    always_ff @(posedge i_clk) begin
        r_yp3 <= r_yp2;
        r_la  <= LW'(r_pc) + LW'(r_px);
        r_lb  <= LW'(r_py) + LW'(r_pz);
        r_mxh <= r_wx * $signed(r_qx[QW-1:LOW]);
        r_myh <= r_wy * $signed(r_qy[QW-1:LOW]);
        r_mxl <= r_wx * $signed({1'b0, r_qx[LOW-1:0]});
        r_myl <= r_wy * $signed({1'b0, r_qy[LOW-1:0]});
    end

    // Stage 4: finish the linear sum and recombine the split products.
    always_ff @(posedge i_clk) begin
        r_yp4 <= r_yp3;
        r_lin <= r_la + r_lb;
        r_tx  <= (AW'(r_mxh) <<< LOW) + AW'(r_mxl);
        r_ty  <= (AW'(r_myh) <<< LOW) + AW'(r_myl);
    end

    // Stage 5: align everything to the accumulator scale and add the rounding half.
    always_ff @(posedge i_clk) begin
        r_u <= (AW'(r_lin) <<< FB) - (AW'(r_yp4) <<< (2 * FB)) + RND;
        r_v <= r_tx + r_ty;
    end

    // Stage 6: full-precision sum.
    always_ff @(posedge i_clk) begin
        r_acc <= r_u - r_v;
    end

    // Drop the extra fraction bits and saturate when the upper bits are not a sign extension.
    assign w_top = r_acc[AW-1:2*FB+VW-1];
    always_comb begin
        n_sat = !((&w_top) || (~|w_top));
        if (n_sat) begin
            n_y = r_acc[AW-1] ? Y_MIN : Y_MAX;
        end else begin
            n_y = r_acc[2*FB+VW-1:2*FB];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        o_y_next    <= n_y;
        o_saturated <= n_sat;
    end

endmodule

@@ rtl/wes_checker.sv @@
`timescale 1ns / 1ps

module wes_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    o_valid,
    input logic [wes_pkg::VW-1:0]  o_y_next,
    input logic                    o_saturated
);
    import wes_pkg::*;

    // Every accepted transaction yields a result once it has passed the whole pipeline.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##7 o_valid)
        else $error("accepted transaction produced no result");

    // No result appears without a matching transaction accepted earlier.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 7))
        else $error("result without an accepted transaction");

    // A clipped result sits at one of the two limits.
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> (o_y_next == Y_MAX || o_y_next == Y_MIN))
        else $error("saturated result is not at a limit");

    // Reset empties the pipeline.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

endmodule

bind wave_equation_stencil_update wes_checker u_wes_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_y_next    (o_y_next),
    .o_saturated (o_saturated)
);

@@ test/wave_equation_stencil_update_tb.sv @@
`timescale 1ns / 1ps

module wave_equation_stencil_update_tb;
    import wes_pkg::*;

    typedef logic signed [VW-1:0] q_t;
    typedef logic signed [127:0] wide_t;

    // One grid node as presented on the input ports.
    typedef struct {
        q_t   x_center;
        q_t   x_minus_x;
        q_t   x_plus_x;
        q_t   x_minus_y;
        q_t   x_plus_y;
        q_t   x_minus_z;
        q_t   x_plus_z;
        q_t   y_prev;
        q_t   coef_center;
        q_t   coef_plus_x;
        q_t   coef_plus_y;
        logic in_region;
    } node_t;

    // One field update as returned on the result ports.
    typedef struct {
        q_t   y_next;
        logic saturated;
    } update_t;

    localparam q_t ONE      = q_t'(1 << FB);
    localparam q_t HALF     = q_t'(1 << (FB - 1));
    localparam q_t QUARTER  = q_t'(1 << (FB - 2));
    localparam q_t MAX_Q    = q_t'(Y_MAX);
    localparam q_t MIN_Q    = q_t'(Y_MIN);
    localparam int SMALL_MAG = 4 << FB;
    localparam int MAX_REPORTS = 10;
    localparam int PIPE_DEPTH = 7;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IW-1:0]    i_cfg_idx;
    logic [VW-1:0]        i_cfg_data;
    logic                 start;
    logic                 busy;
    logic [VW-1:0]        i_x_center;
    logic [VW-1:0]        i_x_minus_x;
    logic [VW-1:0]        i_x_plus_x;
    logic [VW-1:0]        i_x_minus_y;
    logic [VW-1:0]        i_x_plus_y;
    logic [VW-1:0]        i_x_minus_z;
    logic [VW-1:0]        i_x_plus_z;
    logic [VW-1:0]        i_y_prev;
    logic [VW-1:0]        i_coef_center;
    logic [VW-1:0]        i_coef_plus_x;
    logic [VW-1:0]        i_coef_plus_y;
    logic                 i_in_region;
    logic                 o_valid;
    logic [VW-1:0]        o_y_next;
    logic                 o_saturated;

    // Shadow copy of the configuration registers.
    logic cfg_3d;
    q_t   cfg_wc;
    q_t   cfg_wx;
    q_t   cfg_wy;
    q_t   cfg_wz;

    update_t pending_updates[$];
    int      fail_count;
    bit      steady_run;

    wave_equation_stencil_update dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .start         (start),
        .busy          (busy),
        .i_x_center    (i_x_center),
        .i_x_minus_x   (i_x_minus_x),
        .i_x_plus_x    (i_x_plus_x),
        .i_x_minus_y   (i_x_minus_y),
        .i_x_plus_y    (i_x_plus_y),
        .i_x_minus_z   (i_x_minus_z),
        .i_x_plus_z    (i_x_plus_z),
        .i_y_prev      (i_y_prev),
        .i_coef_center (i_coef_center),
        .i_coef_plus_x (i_coef_plus_x),
        .i_coef_plus_y (i_coef_plus_y),
        .i_in_region   (i_in_region),
        .o_valid       (o_valid),
        .o_y_next      (o_y_next),
        .o_saturated   (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block never drains.
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Exact leapfrog update: the full sum at scale 2^(3*FB), one half-up
    // rounding, then saturation to the value width.
    function automatic update_t predict_update(input node_t n);
        wide_t   wc, wx, wy, wz;
        wide_t   c, mx, px, my, py, mz, pz, prev, bc, bx, by;
        wide_t   lin, acc, dbx, dby, r, hi, lo;
        update_t u;
        wc = cfg_wc;  wx = cfg_wx;  wy = cfg_wy;  wz = cfg_wz;
        c = n.x_center;
        mx = n.x_minus_x;  px = n.x_plus_x;
        my = n.x_minus_y;  py = n.x_plus_y;
        mz = n.x_minus_z;  pz = n.x_plus_z;
        prev = n.y_prev;
        bc = n.coef_center;  bx = n.coef_plus_x;  by = n.coef_plus_y;

        lin = wc * c + wx * (mx + px) + wy * (my + py);
        if (cfg_3d)
            lin = lin + wz * (mz + pz);
        acc = (lin <<< FB) - (prev <<< (2 * FB));

        // The 2D stencil adds the variable-coefficient correction.
        if (!cfg_3d) begin
            if (n.in_region) begin
                dbx = wide_t'(1) <<< FB;
                dby = dbx;
            end else begin
                dbx = bx - bc;
                dby = by - bc;
            end
            acc = acc - wx * (px - c) * dbx - wy * (py - c) * dby;
        end

        acc = acc + (wide_t'(1) <<< (2 * FB - 1));
        r = acc >>> (2 * FB);
        hi = (wide_t'(1) <<< (VW - 1)) - 1;
        lo = -(wide_t'(1) <<< (VW - 1));
        if (r > hi) begin
            u.y_next = MAX_Q;
            u.saturated = 1'b1;
        end else if (r < lo) begin
            u.y_next = MIN_Q;
            u.saturated = 1'b1;
        end else begin
            u.y_next = q_t'(r);
            u.saturated = 1'b0;
        end
        return u;
    endfunction

    function automatic q_t rand_q(input bit full);
        int sel;
        int v;
        sel = $urandom_range(99);
        if (sel < 5) begin
            case ($urandom_range(4))
                0: return MAX_Q;
                1: return MIN_Q;
                2: return '0;
                3: return ONE;
                default: return -ONE;
            endcase
        end
        if (full || sel < 20)
            return q_t'($urandom);
        v = int'($urandom_range(2 * SMALL_MAG)) - SMALL_MAG;
        return q_t'(v);
    endfunction

    function automatic node_t rand_node(input bit full);
        node_t n;
        n.x_center    = rand_q(full);
        n.x_minus_x   = rand_q(full);
        n.x_plus_x    = rand_q(full);
        n.x_minus_y   = rand_q(full);
        n.x_plus_y    = rand_q(full);
        n.x_minus_z   = rand_q(full);
        n.x_plus_z    = rand_q(full);
        n.y_prev      = rand_q(full);
        n.coef_center = rand_q(full);
        n.coef_plus_x = rand_q(full);
        n.coef_plus_y = rand_q(full);
        n.in_region   = 1'($urandom_range(1));
        return n;
    endfunction

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] %s", $realtime, msg);
    endtask

    task automatic drive_node(input node_t n);
        i_x_center    = n.x_center;
        i_x_minus_x   = n.x_minus_x;
        i_x_plus_x    = n.x_plus_x;
        i_x_minus_y   = n.x_minus_y;
        i_x_plus_y    = n.x_plus_y;
        i_x_minus_z   = n.x_minus_z;
        i_x_plus_z    = n.x_plus_z;
        i_y_prev      = n.y_prev;
        i_coef_center = n.coef_center;
        i_coef_plus_x = n.coef_plus_x;
        i_coef_plus_y = n.coef_plus_y;
        i_in_region   = n.in_region;
    endtask

    // Present one node and hold it until the block takes the transaction.
    // Called and returns just after a falling edge.
    task automatic send_node(input node_t n);
        drive_node(n);
        start = 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_updates.push_back(predict_update(n));
        @(negedge i_clk);
    endtask

    // Random idle cycles between transactions, with junk on the data ports.
    task automatic idle_gaps();
        while (!steady_run && $urandom_range(99) < 17) begin
            start = 1'b0;
            drive_node(rand_node(1'b1));
            @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start = 1'b0;
        while (pending_updates.size() != 0)
            @(negedge i_clk);
    endtask

    // Register write; only issued while nothing is in flight.
    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [VW-1:0] data);
        start = 1'b0;
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        case (idx)
            CFG_MODE:     cfg_3d = data[0];
            CFG_W_CENTER: cfg_wc = data;
            CFG_W_X:      cfg_wx = data;
            CFG_W_Y:      cfg_wy = data;
            CFG_W_Z:      cfg_wz = data;
            default:      ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_IW'($urandom);
        i_cfg_data = $urandom;
    endtask

    task automatic load_weights(input q_t wc, input q_t wx, input q_t wy, input q_t wz);
        write_reg(CFG_W_CENTER, wc);
        write_reg(CFG_W_X, wx);
        write_reg(CFG_W_Y, wy);
        write_reg(CFG_W_Z, wz);
    endtask

    // Compare each result against the oldest outstanding expectation.
    always @(posedge i_clk) begin : check_updates
        update_t want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_updates.size() == 0) begin
                report_failure($sformatf("unexpected result y_next=%0d saturated=%0b",
                                         $signed(o_y_next), o_saturated));
            end else begin
                want = pending_updates.pop_front();
                if (o_y_next !== want.y_next)
                    report_failure($sformatf("y_next mismatch: expected %0d, got %0d",
                                             want.y_next, $signed(o_y_next)));
                if (o_saturated !== want.saturated)
                    report_failure($sformatf("saturated mismatch: expected %0b, got %0b",
                                             want.saturated, o_saturated));
            end
        end
    end

    // Reset values: 2D, center weight 2.0, neighbor weights zero.
    task automatic test_reset_state();
        node_t n;
        n = '{default: '0};
        send_node(n);
        n = rand_node(1'b1);
        n.x_center = ONE;
        n.y_prev = HALF;
        send_node(n);
        n.x_center = MAX_Q;
        n.y_prev = MIN_Q;
        send_node(n);
        n.x_center = MIN_Q;
        n.y_prev = MAX_Q;
        send_node(n);
        wait_drained();
    endtask

    // Only bit 0 of the mode write counts, and unmapped indexes do nothing.
    task automatic test_register_writes();
        write_reg(CFG_MODE, 32'hFFFF_FFFE);
        for (int k = int'(CFG_W_Z) + 1; k < (1 << CFG_IW); k++)
            write_reg(CFG_IW'(k), $urandom);
        send_node(rand_node(1'b1));
        send_node(rand_node(1'b0));
        wait_drained();
        write_reg(CFG_MODE, 32'h8000_0001);
        send_node(rand_node(1'b1));
        wait_drained();
    endtask

    // Exact half-LSB results round up, for both signs.
    task automatic test_rounding();
        node_t n;
        n = '{default: '0};
        load_weights(HALF, '0, '0, '0);
        n.x_center = 1;
        send_node(n);
        n.x_center = -1;
        send_node(n);
        n.x_center = 3;
        send_node(n);
        n.x_center = -3;
        send_node(n);
        wait_drained();
    endtask

    // Extreme weights and values in both modes, saturating either way.
    task automatic test_extremes();
        node_t n;
        write_reg(CFG_MODE, 1);
        load_weights(MIN_Q, MAX_Q, MIN_Q, MAX_Q);
        n = '{default: MAX_Q, in_region: 1'b1};
        send_node(n);
        n = '{default: MIN_Q, in_region: 1'b0};
        send_node(n);
        n = '{default: '0};
        n.y_prev = MIN_Q;
        send_node(n);
        wait_drained();

        write_reg(CFG_MODE, 0);
        n = '{default: MAX_Q, in_region: 1'b0};
        n.coef_center = MIN_Q;
        n.x_center = MIN_Q;
        send_node(n);
        n.in_region = 1'b1;
        send_node(n);
        n = '{default: MIN_Q, in_region: 1'b0};
        n.coef_plus_y = MAX_Q;
        send_node(n);
        wait_drained();
    endtask

    // 2D stencil inside and outside the flagged region; z inputs and w_z unused.
    task automatic test_region_2d();
        node_t n;
        load_weights(ONE, QUARTER, HALF, MAX_Q);
        for (int k = 0; k < 4; k++) begin
            n = rand_node(1'b0);
            n.in_region = k[0];
            n.x_minus_z = MAX_Q;
            n.x_plus_z = MIN_Q;
            send_node(n);
        end
        wait_drained();
    endtask

    // Random nodes under a series of register settings.
    task automatic test_random_settings();
        for (int phase = 0; phase < 8; phase++) begin
            wait_drained();
            write_reg(CFG_MODE, {31'($urandom_range(255)), phase[0]});
            load_weights(rand_q(phase == 7), rand_q(phase == 7),
                         rand_q(phase == 7), rand_q(phase == 7));
            steady_run = (phase == 3);
            for (int k = 0; k < 60; k++) begin
                idle_gaps();
                send_node(rand_node($urandom_range(99) < 15));
            end
            steady_run = 1'b0;
        end
        wait_drained();
    endtask

    initial begin
        fail_count = 0;
        steady_run = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        start = 1'b0;
        drive_node('{default: '0});
        cfg_3d = 1'b0;
        cfg_wc = W_CENTER_RST;
        cfg_wx = '0;
        cfg_wy = '0;
        cfg_wz = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_register_writes();
        test_rounding();
        test_extremes();
        test_region_2d();
        test_random_settings();

        // Let the pipeline empty, then keep watching for stray results.
        start = 1'b0;
        for (int k = 0; k < 20 * PIPE_DEPTH && pending_updates.size() != 0; k++)
            @(negedge i_clk);
        repeat (2 * PIPE_DEPTH) @(negedge i_clk);
        if (pending_updates.size() != 0)
            report_failure($sformatf("%0d expected updates never arrived",
                                     pending_updates.size()));

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
